### sv/fst_pkg.sv
// shared types, character codes and limits for the format spec tokenizer
package fst_pkg;

  localparam int NUM_BITS    = 16;
  localparam int VAL_W       = 17;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    CL_HASH,
    CL_ZERO,
    CL_DIGIT,
    CL_MINUS,
    CL_SPACE,
    CL_PLUS,
    CL_Z,
    CL_H,
    CL_L,
    CL_STAR,
    CL_DOT,
    CL_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_WDIG,
    MODE_DOT,
    MODE_PDIG,
    MODE_HOLD_H,
    MODE_HOLD_L
  } scan_mode_t;

  typedef struct packed {
    char_class_t cls;
    logic [7:0]  ch;
  } token_t;

endpackage

### sv/fst_classify.sv
// front end: accepts characters and tags each with its character class
module fst_classify import fst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  output logic       tok_valid,
  input  logic       tok_ready,
  output token_t     tok
);

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    if (c == CH_HASH)                         r = CL_HASH;
    else if (c == CH_ZERO)                    r = CL_ZERO;
    else if (c > CH_ZERO && c <= CH_NINE)     r = CL_DIGIT;
    else if (c == CH_MINUS)                   r = CL_MINUS;
    else if (c == CH_SPACE)                   r = CL_SPACE;
    else if (c == CH_PLUS)                    r = CL_PLUS;
    else if (c == CH_Z)                       r = CL_Z;
    else if (c == CH_H)                       r = CL_H;
    else if (c == CH_L)                       r = CL_L;
    else if (c == CH_STAR)                    r = CL_STAR;
    else if (c == CH_DOT)                     r = CL_DOT;
    else                                      r = CL_OTHER;
    return r;
  endfunction

  assign in_ready = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (in_ready) begin
      tok_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok.cls <= classify(in_ch);
      tok.ch  <= in_ch;
    end
  end

endmodule

### sv/fst_queue.sv
// short token queue between the classifier and the scanner
module fst_queue import fst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  token_t in_tok,
  output logic   out_valid,
  input  logic   out_ready,
  output token_t out_tok
);

  token_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/fst_scan.sv
// back end: scan state, field accumulators and the result register
module fst_scan import fst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  output logic              tok_ready,
  input  token_t            tok,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [4:0]        res_flag_bits,
  output logic [4:0]        res_modifier_bits,
  output logic [VAL_W-1:0]  res_width_value,
  output logic [VAL_W-1:0]  res_precision_value,
  output logic              res_width_star,
  output logic              res_precision_star,
  output logic [7:0]        res_conv_char,
  output logic [7:0]        res_spec_length
);

  localparam logic [NUM_BITS-1:0] NUM_MAX = '1;

  function automatic logic [VAL_W-1:0] accum(input logic [VAL_W-1:0] v,
                                             input logic [3:0] d);
    logic [NUM_BITS-1:0] base;
    logic [NUM_BITS+3:0] wide;
    logic [NUM_BITS+3:0] n;
    base = v[VAL_W-1] ? '0 : v[NUM_BITS-1:0];
    wide = {4'b0, base};
    n    = (wide << 3) + (wide << 1) + {{NUM_BITS{1'b0}}, d};
    if (n > {4'b0, NUM_MAX}) begin
      n = {4'b0, NUM_MAX};
    end
    return VAL_W'(n[NUM_BITS-1:0]);
  endfunction

  scan_mode_t        mode, mode_next;
  logic [4:0]        flag_acc, flag_next;
  logic [4:0]        modifier_acc, modifier_next;
  logic [1:0]        star_acc, star_next;
  logic [VAL_W-1:0]  width_acc, width_next;
  logic [VAL_W-1:0]  precision_acc, precision_next;
  logic [7:0]        length_acc;
  logic              scan;
  logic              emit;
  logic              is_digit;
  logic [3:0]        digit;
  logic              pop;

  assign tok_ready = !res_valid || res_ready;
  assign pop       = tok_valid && tok_ready;
  assign is_digit  = (tok.cls == CL_ZERO) || (tok.cls == CL_DIGIT);
  assign digit     = tok.ch[3:0];

  always_comb begin
    mode_next      = MODE_PLAIN;
    flag_next      = flag_acc;
    modifier_next  = modifier_acc;
    star_next      = star_acc;
    width_next     = width_acc;
    precision_next = precision_acc;
    scan           = 1'b0;
    emit           = 1'b0;
    unique case (mode)
      MODE_HOLD_H: begin
        if (tok.cls == CL_H) modifier_next[2] = 1'b1;
        else begin
          modifier_next[1] = 1'b1;
          scan = 1'b1;
        end
      end
      MODE_HOLD_L: begin
        if (tok.cls == CL_L) modifier_next[4] = 1'b1;
        else begin
          modifier_next[3] = 1'b1;
          scan = 1'b1;
        end
      end
      MODE_WDIG: begin
        if (is_digit) begin
          width_next = accum(width_acc, digit);
          mode_next  = MODE_WDIG;
        end else begin
          scan = 1'b1;
        end
      end
      MODE_DOT: begin
        if (tok.cls == CL_STAR) begin
          precision_next = '1;
          star_next[1]   = 1'b1;
        end else if (is_digit) begin
          precision_next = accum(precision_acc, digit);
          mode_next      = MODE_PDIG;
        end else begin
          scan = 1'b1;
        end
      end
      MODE_PDIG: begin
        if (is_digit) begin
          precision_next = accum(precision_acc, digit);
          mode_next      = MODE_PDIG;
        end else begin
          scan = 1'b1;
        end
      end
      default: scan = 1'b1;
    endcase
    if (scan) begin
      unique case (tok.cls)
        CL_HASH:  flag_next[0] = 1'b1;
        CL_ZERO:  flag_next[1] = 1'b1;
        CL_MINUS: flag_next[2] = 1'b1;
        CL_SPACE: flag_next[3] = 1'b1;
        CL_PLUS:  flag_next[4] = 1'b1;
        CL_Z:     modifier_next[0] = 1'b1;
        CL_H:     mode_next = MODE_HOLD_H;
        CL_L:     mode_next = MODE_HOLD_L;
        CL_STAR: begin
          width_next   = '1;
          star_next[0] = 1'b1;
        end
        CL_DOT: begin
          precision_next = '0;
          mode_next      = MODE_DOT;
        end
        CL_DIGIT: begin
          width_next = accum('0, digit);
          mode_next  = MODE_WDIG;
        end
        default:  emit = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PLAIN;
      flag_acc      <= '0;
      modifier_acc  <= '0;
      star_acc      <= '0;
      width_acc     <= '1;
      precision_acc <= '1;
      length_acc    <= '0;
      res_valid     <= 1'b0;
    end else begin
      res_valid <= (pop && emit) || (res_valid && !res_ready);
      if (pop) begin
        if (emit) begin
          mode          <= MODE_PLAIN;
          flag_acc      <= '0;
          modifier_acc  <= '0;
          star_acc      <= '0;
          width_acc     <= '1;
          precision_acc <= '1;
          length_acc    <= '0;
        end else begin
          mode          <= mode_next;
          flag_acc      <= flag_next;
          modifier_acc  <= modifier_next;
          star_acc      <= star_next;
          width_acc     <= width_next;
          precision_acc <= precision_next;
          if (length_acc != '1) begin
            length_acc <= length_acc + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_flag_bits       <= flag_next;
      res_modifier_bits   <= modifier_next;
      res_width_value     <= width_next;
      res_precision_value <= precision_next;
      res_width_star      <= star_next[0];
      res_precision_star  <= star_next[1];
      res_conv_char       <= tok.ch;
      res_spec_length     <= length_acc;
    end
  end

endmodule

### sv/format_spec_tokenizer_unit.sv
// top level of the format spec tokenizer
// Takes the characters after a percent sign, one per transaction, and sends
// one result transaction when the conversion type character arrives. Every
// character is accepted in its own cycle and the block sustains one
// character per clock while the result side keeps up; the scanner takes
// one token a cycle from a four-entry queue while its result register is
// free, and a result passes through the classifier register, a queue entry
// and the result register before it is offered. Width and precision
// saturate at 65535, the length count at 255.
module format_spec_tokenizer_unit import fst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch
  output logic        m_tvalid,
  input  logic        m_tready,
  // flag_bits[4:0], modifier_bits[9:5], width_value[26:10],
  // precision_value[43:27], width_star[44], precision_star[45],
  // conv_char[53:46], spec_length[61:54], zero fill[63:62]
  output logic [63:0] m_tdata
);

  logic             cls_valid;
  logic             cls_ready;
  token_t           cls_tok;
  logic             q_valid;
  logic             q_ready;
  token_t           q_tok;
  logic [4:0]       flag_bits;
  logic [4:0]       modifier_bits;
  logic [VAL_W-1:0] width_value;
  logic [VAL_W-1:0] precision_value;
  logic             width_star;
  logic             precision_star;
  logic [7:0]       conv_char;
  logic [7:0]       spec_length;

  fst_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ch     (s_tdata),
    .tok_valid (cls_valid),
    .tok_ready (cls_ready),
    .tok       (cls_tok)
  );

  fst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_tok    (cls_tok),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_tok   (q_tok)
  );

  fst_scan u_scan (
    .clk                 (clk),
    .rst                 (rst),
    .tok_valid           (q_valid),
    .tok_ready           (q_ready),
    .tok                 (q_tok),
    .res_valid           (m_tvalid),
    .res_ready           (m_tready),
    .res_flag_bits       (flag_bits),
    .res_modifier_bits   (modifier_bits),
    .res_width_value     (width_value),
    .res_precision_value (precision_value),
    .res_width_star      (width_star),
    .res_precision_star  (precision_star),
    .res_conv_char       (conv_char),
    .res_spec_length     (spec_length)
  );

  assign m_tdata = {2'b00, spec_length, conv_char, precision_star, width_star,
                    precision_value, width_value, modifier_bits, flag_bits};

endmodule

### sv/fst_checker.sv
// port-level checks for the format spec tokenizer and their binding
module fst_checker import fst_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // the type character never belongs to a consumed class
  a_conv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !((m_tdata[53:46] >= CH_ZERO && m_tdata[53:46] <= CH_NINE) ||
                   m_tdata[53:46] == CH_HASH || m_tdata[53:46] == CH_MINUS ||
                   m_tdata[53:46] == CH_SPACE || m_tdata[53:46] == CH_PLUS ||
                   m_tdata[53:46] == CH_Z || m_tdata[53:46] == CH_H ||
                   m_tdata[53:46] == CH_L || m_tdata[53:46] == CH_STAR ||
                   m_tdata[53:46] == CH_DOT))
    else $error("conversion character is a spec character");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[26] |-> m_tdata[26:10] == 17'h1FFFF)
    else $error("negative width other than -1");

  a_prec_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[43] |-> m_tdata[43:27] == 17'h1FFFF)
    else $error("negative precision other than -1");

endmodule

bind format_spec_tokenizer_unit fst_checker u_fst_checker (.*);

### bench/tb.sv
// self-checking bench for format_spec_tokenizer_unit: directed table plus random spec streams
module tb import fst_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT = 3;
  localparam int ITEM_GOAL = 1400;
  localparam int PARK_CYCLES = 300;
  localparam logic [31:0] NUM_MAX = (32'd1 << NUM_BITS) - 32'd1;

  typedef struct packed {
    logic [1:0]  pad;
    logic [7:0]  len;
    logic [7:0]  conv;
    logic        p_star;
    logic        w_star;
    logic [16:0] prec;
    logic [16:0] width;
    logic [4:0]  mods;
    logic [4:0]  flags;
  } spec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    spec_t      want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;

  logic  drv_typed;
  spec_t drv_want;

  scan_mode_t  cur_mode;
  logic [4:0]  cur_flags;
  logic [4:0]  cur_mods;
  logic [1:0]  cur_stars;
  logic [16:0] cur_width;
  logic [16:0] cur_prec;
  logic [7:0]  cur_len;

  spec_t       spec_q[$];
  dir_row_t    dir_rows[$];
  logic [7:0]  spec_buf[$];
  int          err_cnt;
  int          sent_cnt;
  int unsigned burst_left;
  bit          park_req;

  format_spec_tokenizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_cnt++;
    if (err_cnt <= 100) begin
      $display("mismatch: %s got %0h want %0h", what, got, want);
    end
  endtask

  task automatic compare_spec(input spec_t got, input spec_t want);
    if (got.flags != want.flags) report_mismatch("flag_bits", got.flags, want.flags);
    if (got.mods != want.mods) report_mismatch("modifier_bits", got.mods, want.mods);
    if (got.width != want.width) report_mismatch("width_value", got.width, want.width);
    if (got.prec != want.prec) report_mismatch("precision_value", got.prec, want.prec);
    if (got.w_star != want.w_star) report_mismatch("width_star", got.w_star, want.w_star);
    if (got.p_star != want.p_star) report_mismatch("precision_star", got.p_star, want.p_star);
    if (got.conv != want.conv) report_mismatch("conv_char", got.conv, want.conv);
    if (got.len != want.len) report_mismatch("spec_length", got.len, want.len);
    if (got.pad != want.pad) report_mismatch("zero fill", got.pad, want.pad);
  endtask

  function automatic spec_t mk_spec(input logic [4:0] f, input logic [4:0] m, input int w,
                                    input int p, input logic ws, input logic ps,
                                    input logic [7:0] cv, input logic [7:0] n);
    spec_t s;
    s        = '0;
    s.flags  = f;
    s.mods   = m;
    s.width  = w[16:0];
    s.prec   = p[16:0];
    s.w_star = ws;
    s.p_star = ps;
    s.conv   = cv;
    s.len    = n;
    return s;
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [16:0] next_num(input logic [16:0] v, input logic [7:0] c);
    logic [31:0] base;
    logic [31:0] n;
    base = v[16] ? 32'd0 : {15'd0, v};
    n = base * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
    if (n > NUM_MAX) n = NUM_MAX;
    return n[16:0];
  endfunction

  task automatic clear_spec_state();
    cur_mode  = MODE_PLAIN;
    cur_flags = '0;
    cur_mods  = '0;
    cur_stars = '0;
    cur_width = '1;
    cur_prec  = '1;
    cur_len   = '0;
  endtask

  function automatic bit take_plain(input logic [7:0] c);
    take_plain = 1'b1;
    case (c)
      CH_HASH:  cur_flags[0] = 1'b1;
      CH_ZERO:  cur_flags[1] = 1'b1;
      CH_MINUS: cur_flags[2] = 1'b1;
      CH_SPACE: cur_flags[3] = 1'b1;
      CH_PLUS:  cur_flags[4] = 1'b1;
      CH_Z:     cur_mods[0] = 1'b1;
      CH_H:     cur_mode = MODE_HOLD_H;
      CH_L:     cur_mode = MODE_HOLD_L;
      CH_STAR: begin
        cur_width    = '1;
        cur_stars[0] = 1'b1;
      end
      CH_DOT: begin
        cur_prec = '0;
        cur_mode = MODE_DOT;
      end
      default: begin
        if (is_dig(c)) begin
          cur_width = next_num('0, c);
          cur_mode  = MODE_WDIG;
        end else begin
          take_plain = 1'b0;
        end
      end
    endcase
  endfunction

  task automatic predict_spec(input logic [7:0] c, output bit hit, output spec_t res);
    scan_mode_t prev;
    bit handled;
    bit took;
    prev     = cur_mode;
    cur_mode = MODE_PLAIN;
    handled  = 1'b0;
    res      = '0;
    case (prev)
      MODE_HOLD_H: begin
        if (c == CH_H) begin
          cur_mods[2] = 1'b1;
          handled = 1'b1;
        end else begin
          cur_mods[1] = 1'b1;
        end
      end
      MODE_HOLD_L: begin
        if (c == CH_L) begin
          cur_mods[4] = 1'b1;
          handled = 1'b1;
        end else begin
          cur_mods[3] = 1'b1;
        end
      end
      MODE_WDIG: begin
        if (is_dig(c)) begin
          cur_width = next_num(cur_width, c);
          cur_mode  = MODE_WDIG;
          handled   = 1'b1;
        end
      end
      MODE_DOT: begin
        if (c == CH_STAR) begin
          cur_prec     = '1;
          cur_stars[1] = 1'b1;
          handled      = 1'b1;
        end else if (is_dig(c)) begin
          cur_prec = next_num(cur_prec, c);
          cur_mode = MODE_PDIG;
          handled  = 1'b1;
        end
      end
      MODE_PDIG: begin
        if (is_dig(c)) begin
          cur_prec = next_num(cur_prec, c);
          cur_mode = MODE_PDIG;
          handled  = 1'b1;
        end
      end
      default: ;
    endcase
    took = handled ? 1'b1 : take_plain(c);
    hit  = !took;
    if (took) begin
      if (cur_len != 8'hFF) cur_len = cur_len + 8'd1;
    end else begin
      res = mk_spec(cur_flags, cur_mods, {{15{cur_width[16]}}, cur_width},
                    {{15{cur_prec[16]}}, cur_prec}, cur_stars[0], cur_stars[1], c, cur_len);
      clear_spec_state();
    end
  endtask

  // input and output transactions observed at the same edge
  always @(posedge clk) begin
    bit    hit;
    spec_t res;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (spec_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 0);
        end else begin
          compare_spec(spec_t'(m_tdata), spec_q.pop_front());
        end
      end
      if (s_tvalid && s_tready) begin
        predict_spec(s_tdata, hit, res);
        if (drv_typed) spec_q.push_back(drv_want);
        else if (hit) spec_q.push_back(res);
      end
    end
  end

  // receiver: random ready styles plus one long park
  initial begin
    int style;
    int style_cnt;
    int park_left;
    m_tready  = 1'b0;
    style     = 0;
    style_cnt = 0;
    park_left = 0;
    forever begin
      @(negedge clk);
      if (park_req) begin
        park_left = PARK_CYCLES;
        park_req  = 1'b0;
      end
      if (park_left > 0) begin
        park_left--;
        m_tready <= 1'b0;
      end else begin
        if (style_cnt == 0) begin
          style     = $urandom_range(0, 3);
          style_cnt = $urandom_range(8, 48);
        end
        style_cnt--;
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic typed, input spec_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid  <= 1'b1;
    s_tdata   <= c;
    drv_typed <= typed;
    drv_want  <= want;
    do @(posedge clk); while (!s_tready);
    sent_cnt++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (spec_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] c, input logic typed, input spec_t want);
    dir_row_t r;
    r.ch    = c;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  function automatic logic [7:0] pick_conv();
    string letters;
    logic [7:0] c;
    letters = "diouxXeEfFgGaAcspn%";
    if ($urandom_range(0, 1) == 0) return letters[$urandom_range(0, letters.len() - 1)];
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_dig(c) || c == CH_HASH || c == CH_MINUS || c == CH_SPACE ||
               c == CH_PLUS || c == CH_Z || c == CH_H || c == CH_L ||
               c == CH_STAR || c == CH_DOT);
    return c;
  endfunction

  task automatic push_digits(input int n);
    repeat (n) spec_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic build_spec(input int spec_no);
    int kind;
    spec_buf.delete();
    kind = $urandom_range(0, 99);
    if (spec_no == 7) begin
      // length count runs past its saturation point
      repeat (300) spec_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_Z);
      push_digits(4);
      spec_buf.push_back(pick_conv());
    end else if (kind < 20) begin
      repeat ($urandom_range(1, 8)) spec_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 7))
          0: begin
            case ($urandom_range(0, 4))
              0: spec_buf.push_back(CH_HASH);
              1: spec_buf.push_back(CH_ZERO);
              2: spec_buf.push_back(CH_MINUS);
              3: spec_buf.push_back(CH_SPACE);
              default: spec_buf.push_back(CH_PLUS);
            endcase
          end
          1: spec_buf.push_back(CH_Z);
          2: repeat ($urandom_range(1, 3)) spec_buf.push_back(CH_H);
          3: repeat ($urandom_range(1, 2)) spec_buf.push_back(CH_L);
          4: push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) :
                         $urandom_range(1, 3));
          5: spec_buf.push_back(CH_STAR);
          6: begin
            spec_buf.push_back(CH_DOT);
            push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) :
                        $urandom_range(0, 3));
          end
          default: begin
            spec_buf.push_back(CH_DOT);
            spec_buf.push_back(CH_STAR);
          end
        endcase
      end
      // a few specs run on into the next one without a type character
      if (kind >= 28) spec_buf.push_back(pick_conv());
    end
  endtask

  initial begin
    int n_spec;
    int waited;
    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    drv_typed  = 1'b0;
    drv_want   = '0;
    err_cnt    = 0;
    sent_cnt   = 0;
    burst_left = 0;
    park_req   = 1'b0;
    clear_spec_state();

    add_row("d", 1'b1, mk_spec(5'h00, 5'h00, -1, -1, 1'b0, 1'b0, "d", 8'd0));
    add_row(CH_HASH, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, '0);
    add_row(CH_MINUS, 1'b0, '0);
    add_row(CH_SPACE, 1'b0, '0);
    add_row(CH_PLUS, 1'b0, '0);
    add_row(CH_DOT, 1'b0, '0);
    add_row(8'h00, 1'b1, mk_spec(5'h1F, 5'h00, -1, 0, 1'b0, 1'b0, 8'h00, 8'd6));
    add_row(CH_Z, 1'b0, '0);
    add_row(CH_H, 1'b0, '0);
    add_row(CH_H, 1'b0, '0);
    add_row(CH_H, 1'b0, '0);
    add_row(CH_L, 1'b0, '0);
    add_row(CH_L, 1'b0, '0);
    add_row(CH_L, 1'b0, '0);
    add_row("n", 1'b1, mk_spec(5'h00, 5'h1F, -1, -1, 1'b0, 1'b0, "n", 8'd7));
    add_row(CH_STAR, 1'b0, '0);
    add_row(CH_ZERO + 8'd7, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, '0);
    add_row(CH_DOT, 1'b0, '0);
    add_row(CH_STAR, 1'b0, '0);
    add_row("f", 1'b1, mk_spec(5'h00, 5'h00, 65535, -1, 1'b1, 1'b1, "f", 8'd8));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
    hold_until_drained();

    n_spec = 0;
    while (sent_cnt < ITEM_GOAL) begin
      build_spec(n_spec);
      foreach (spec_buf[i]) send_char(spec_buf[i], 1'b0, '0);
      n_spec++;
      if (n_spec == 12) park_req = 1'b1;
      if (n_spec % 80 == 40) hold_until_drained();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (spec_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (spec_q.size() != 0) report_mismatch("results missing", spec_q.size(), 0);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
